/* rtl/sard_pkg.sv */
// Package for the stick axial/radial dead zone: types, constants and datapath step functions.
`default_nettype none
package sard_pkg;

  localparam int GainFracBits = 16;
  localparam int MagFracBits  = 8;

  localparam int CfgW   = 17;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_AXIS_THR   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_AXIS_GPOS  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_AXIS_GNEG  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RAD_THR    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_RAD_GAIN   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MAG_LIMIT  = 3'd5;

  localparam logic [14:0] RST_AXIS_THR  = 15'd4095;
  localparam logic [16:0] RST_AXIS_GAIN = 17'd74896;
  localparam logic [14:0] RST_RAD_THR   = 15'd4095;
  localparam logic [16:0] RST_RAD_GAIN  = 17'd74896;
  localparam logic [14:0] RST_MAG_LIMIT = 15'd32767;

  // pipeline layout
  localparam int SqStages = 8;
  localparam int SqSteps  = 3;
  localparam int DvStages = 6;
  localparam int DvSteps  = 3;
  localparam int StSq  = 4;
  localparam int StCl  = StSq + SqStages;
  localparam int StRm  = StCl + 1;
  localparam int StNm  = StRm + 1;
  localparam int StDv  = StNm + 1;
  localparam int StOut = StDv + DvStages;
  localparam int NumSt = StOut + 1;

  typedef struct packed {
    logic [32:0] prod;
    logic        neg;
    logic        live;
  } axp_t;

  typedef struct packed {
    logic [32:0] px;
    logic [32:0] py;
    logic        negx;
    logic        negy;
    logic        livex;
    logic        livey;
  } st0_t;

  typedef struct packed {
    logic [15:0] ax;
    logic [15:0] ay;
    logic        negx;
    logic        negy;
  } st1_t;

  typedef struct packed {
    logic [31:0] sqx;
    logic [31:0] sqy;
    logic [15:0] ax;
    logic [15:0] ay;
    logic        negx;
    logic        negy;
  } st2_t;

  typedef struct packed {
    logic [26:0] rem;
    logic [23:0] root;
    logic [47:0] rad;
    logic [15:0] ax;
    logic [15:0] ay;
    logic        negx;
    logic        negy;
  } sq_t;

  typedef struct packed {
    logic [22:0] diff;
    logic [23:0] mag;
    logic        dead;
    logic [15:0] ax;
    logic [15:0] ay;
    logic        negx;
    logic        negy;
  } cl_t;

  typedef struct packed {
    logic [39:0] prod;
    logic [23:0] mag;
    logic        dead;
    logic [15:0] ax;
    logic [15:0] ay;
    logic        negx;
    logic        negy;
  } rm_t;

  typedef struct packed {
    logic [23:0] rem;
    logic [17:0] low;
    logic [17:0] q;
  } dp_t;

  typedef struct packed {
    dp_t         dx;
    dp_t         dy;
    logic [23:0] mag;
    logic        dead;
    logic        negx;
    logic        negy;
  } dv_t;

  function automatic axp_t axial(input logic signed [15:0] v, input logic [14:0] t,
                                 input logic [16:0] gp, input logic [16:0] gn);
    axp_t r;
    logic signed [16:0] vs;
    logic signed [16:0] ts;
    logic signed [16:0] dd;
    vs = {v[15], v};
    ts = {2'b00, t};
    r.prod = '0;
    r.neg  = 1'b0;
    r.live = 1'b0;
    if (vs > ts) begin
      dd = vs - ts;
      r.prod = 33'(dd[15:0]) * 33'(gp);
      r.live = 1'b1;
    end else if (vs < -ts) begin
      dd = -(vs + ts);
      r.prod = 33'(dd[15:0]) * 33'(gn);
      r.neg  = 1'b1;
      r.live = 1'b1;
    end
    return r;
  endfunction

  // magnitude after int16 saturation
  function automatic logic [15:0] clip_mag(input logic neg, input logic [16:0] m);
    logic [15:0] r;
    if (neg) r = (m >= 17'd32768) ? 16'h8000 : m[15:0];
    else     r = (m >= 17'd32767) ? 16'h7fff : m[15:0];
    return r;
  endfunction

  function automatic logic [15:0] sat16(input logic neg, input logic [16:0] m);
    logic [15:0] r;
    if (neg) r = (m >= 17'd32768) ? 16'h8000 : 16'(-m[15:0]);
    else     r = (m >= 17'd32767) ? 16'h7fff : m[15:0];
    return r;
  endfunction

  function automatic sq_t sqrt_step(input sq_t s);
    sq_t r;
    logic [26:0] rem2;
    logic [26:0] trial;
    r     = s;
    rem2  = {s.rem[24:0], s.rad[47:46]};
    trial = {1'b0, s.root, 2'b01};
    if (rem2 >= trial) begin
      r.rem  = rem2 - trial;
      r.root = {s.root[22:0], 1'b1};
    end else begin
      r.rem  = rem2;
      r.root = {s.root[22:0], 1'b0};
    end
    r.rad = {s.rad[45:0], 2'b00};
    return r;
  endfunction

  function automatic dp_t div_step(input dp_t p, input logic [23:0] d);
    dp_t r;
    logic [24:0] r2;
    r2 = {p.rem, p.low[17]};
    if (r2 >= {1'b0, d}) begin
      r.rem = 24'(r2 - {1'b0, d});
      r.q   = {p.q[16:0], 1'b1};
    end else begin
      r.rem = r2[23:0];
      r.q   = {p.q[16:0], 1'b0};
    end
    r.low = {p.low[16:0], 1'b0};
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/sard_if.sv */
// Stream interfaces for stick readings and conditioned results.
`default_nettype none
interface sard_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] stick_x;
  logic signed [15:0] stick_y;
  modport source (output valid, output stick_x, output stick_y, input ready);
  modport sink (input valid, input stick_x, input stick_y, output ready);
endinterface

interface sard_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic               in_dead_zone;
  modport source (output valid, output out_x, output out_y, output in_dead_zone, input ready);
  modport sink (input valid, input out_x, input out_y, input in_dead_zone, output ready);
endinterface
`default_nettype wire

/* rtl/stick_axial_radial_dead_zone.sv */
// Top level: axial dead zone, pipelined magnitude, radial dead zone and rescale.
// One reading per cycle enters while the output side keeps taking, then moves through 22
// register stages (8 for the 24-bit square root, 6 for the two 18-bit quotients). Each
// stage holds its item only while the stage after it is full and stalled, so empty slots
// close up and a new transaction is taken while a result waits. Configuration registers
// feed the datapath directly; the user must write them only while idle (unenforced).
`default_nettype none
module stick_axial_radial_dead_zone (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [sard_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [sard_pkg::CfgW-1:0]    cfg_wdata_i,
  sard_in_if.sink                           stick_i,
  sard_out_if.source                        result_o
);
  import sard_pkg::*;

  logic [14:0] axis_thr_q;
  logic [16:0] gpos_q;
  logic [16:0] gneg_q;
  logic [14:0] rad_thr_q;
  logic [16:0] rad_gain_q;
  logic [14:0] mag_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_thr_q <= RST_AXIS_THR;
      gpos_q     <= RST_AXIS_GAIN;
      gneg_q     <= RST_AXIS_GAIN;
      rad_thr_q  <= RST_RAD_THR;
      rad_gain_q <= RST_RAD_GAIN;
      mag_lim_q  <= RST_MAG_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_AXIS_THR:  axis_thr_q <= cfg_wdata_i[14:0];
        CFG_AXIS_GPOS: gpos_q     <= cfg_wdata_i;
        CFG_AXIS_GNEG: gneg_q     <= cfg_wdata_i;
        CFG_RAD_THR:   rad_thr_q  <= cfg_wdata_i[14:0];
        CFG_RAD_GAIN:  rad_gain_q <= cfg_wdata_i;
        CFG_MAG_LIMIT: mag_lim_q  <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // valid chain
  logic [NumSt-1:0] vld_q;
  logic [NumSt:0]   adv;
  logic [NumSt-1:0] vin;

  always_comb begin
    adv[NumSt] = result_o.ready;
    for (int k = NumSt - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign vin           = {vld_q[NumSt-2:0], stick_i.valid};
  assign stick_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumSt; k++) begin
        if (adv[k]) vld_q[k] <= vin[k];
      end
    end
  end

  // stage 0: axial product
  st0_t s0_d, s0_q;
  axp_t apx, apy;
  always_comb begin
    apx = axial(stick_i.stick_x, axis_thr_q, gpos_q, gneg_q);
    apy = axial(stick_i.stick_y, axis_thr_q, gpos_q, gneg_q);
    s0_d.px    = apx.prod;
    s0_d.py    = apy.prod;
    s0_d.negx  = apx.neg;
    s0_d.negy  = apy.neg;
    s0_d.livex = apx.live;
    s0_d.livey = apy.live;
  end
  always_ff @(posedge clk_i) if (adv[0]) s0_q <= s0_d;

  // stage 1: saturate
  st1_t s1_d, s1_q;
  always_comb begin
    s1_d.ax   = s0_q.livex ? clip_mag(s0_q.negx, s0_q.px[32:16]) : 16'd0;
    s1_d.ay   = s0_q.livey ? clip_mag(s0_q.negy, s0_q.py[32:16]) : 16'd0;
    s1_d.negx = s0_q.negx & s0_q.livex;
    s1_d.negy = s0_q.negy & s0_q.livey;
  end
  always_ff @(posedge clk_i) if (adv[1]) s1_q <= s1_d;

  // stage 2: squares
  st2_t s2_d, s2_q;
  always_comb begin
    s2_d.sqx  = 32'(s1_q.ax) * 32'(s1_q.ax);
    s2_d.sqy  = 32'(s1_q.ay) * 32'(s1_q.ay);
    s2_d.ax   = s1_q.ax;
    s2_d.ay   = s1_q.ay;
    s2_d.negx = s1_q.negx;
    s2_d.negy = s1_q.negy;
  end
  always_ff @(posedge clk_i) if (adv[2]) s2_q <= s2_d;

  // stage 3: sum, square root seed
  sq_t s3_d, s3_q;
  always_comb begin
    s3_d.rem  = '0;
    s3_d.root = '0;
    s3_d.rad  = {s2_q.sqx + s2_q.sqy, 16'd0};
    s3_d.ax   = s2_q.ax;
    s3_d.ay   = s2_q.ay;
    s3_d.negx = s2_q.negx;
    s3_d.negy = s2_q.negy;
  end
  always_ff @(posedge clk_i) if (adv[3]) s3_q <= s3_d;

  // square root stages
  sq_t sq_q [SqStages];
  for (genvar g = 0; g < SqStages; g++) begin : g_sq
    sq_t src, nxt;
    if (g == 0) begin : g_first
      assign src = s3_q;
    end else begin : g_rest
      assign src = sq_q[g-1];
    end
    always_comb begin
      nxt = src;
      for (int j = 0; j < SqSteps; j++) nxt = sqrt_step(nxt);
    end
    always_ff @(posedge clk_i) if (adv[StSq+g]) sq_q[g] <= nxt;
  end

  // clamp and radial dead zone
  cl_t cl_d, cl_q;
  sq_t sql;
  logic [22:0] thr, lim, clamped;
  always_comb begin
    sql     = sq_q[SqStages-1];
    thr     = {rad_thr_q, 8'd0};
    lim     = {mag_lim_q, 8'd0};
    clamped = (sql.root > {1'b0, lim}) ? lim : sql.root[22:0];
    cl_d.dead = (sql.root <= {1'b0, thr}) || (clamped < thr);
    cl_d.diff = clamped - thr;
    cl_d.mag  = sql.root;
    cl_d.ax   = sql.ax;
    cl_d.ay   = sql.ay;
    cl_d.negx = sql.negx;
    cl_d.negy = sql.negy;
  end
  always_ff @(posedge clk_i) if (adv[StCl]) cl_q <= cl_d;

  // radius product
  rm_t rm_d, rm_q;
  always_comb begin
    rm_d.prod = 40'(cl_q.diff) * 40'(rad_gain_q);
    rm_d.mag  = cl_q.mag;
    rm_d.dead = cl_q.dead;
    rm_d.ax   = cl_q.ax;
    rm_d.ay   = cl_q.ay;
    rm_d.negx = cl_q.negx;
    rm_d.negy = cl_q.negy;
  end
  always_ff @(posedge clk_i) if (adv[StRm]) rm_q <= rm_d;

  // numerators, divider seed
  dv_t nm_d, nm_q;
  logic [23:0] radius;
  logic [41:0] nx, ny;
  always_comb begin
    radius     = rm_q.prod[39:16];
    nx         = 42'(rm_q.ax) * 42'(radius);
    ny         = 42'(rm_q.ay) * 42'(radius);
    nm_d.dx.rem = nx[41:18];
    nm_d.dx.low = nx[17:0];
    nm_d.dx.q   = '0;
    nm_d.dy.rem = ny[41:18];
    nm_d.dy.low = ny[17:0];
    nm_d.dy.q   = '0;
    nm_d.mag    = rm_q.mag;
    nm_d.dead   = rm_q.dead;
    nm_d.negx   = rm_q.negx;
    nm_d.negy   = rm_q.negy;
  end
  always_ff @(posedge clk_i) if (adv[StNm]) nm_q <= nm_d;

  // divider stages
  dv_t dv_q [DvStages];
  for (genvar g = 0; g < DvStages; g++) begin : g_dv
    dv_t src, nxt;
    if (g == 0) begin : g_first
      assign src = nm_q;
    end else begin : g_rest
      assign src = dv_q[g-1];
    end
    always_comb begin
      nxt = src;
      for (int j = 0; j < DvSteps; j++) begin
        nxt.dx = div_step(nxt.dx, src.mag);
        nxt.dy = div_step(nxt.dy, src.mag);
      end
    end
    always_ff @(posedge clk_i) if (adv[StDv+g]) dv_q[g] <= nxt;
  end

  // output register
  dv_t dvl;
  logic [15:0] ox_d, oy_d, ox_q, oy_q;
  logic        dz_q;
  always_comb begin
    dvl  = dv_q[DvStages-1];
    ox_d = dvl.dead ? 16'd0 : sat16(dvl.negx, dvl.dx.q[16:0]);
    oy_d = dvl.dead ? 16'd0 : sat16(dvl.negy, dvl.dy.q[16:0]);
  end
  always_ff @(posedge clk_i) begin
    if (adv[StOut]) begin
      ox_q <= ox_d;
      oy_q <= oy_d;
      dz_q <= dvl.dead;
    end
  end

  assign result_o.valid        = vld_q[StOut];
  assign result_o.out_x        = ox_q;
  assign result_o.out_y        = oy_q;
  assign result_o.in_dead_zone = dz_q;

endmodule
`default_nettype wire

/* rtl/sard_chk.sv */
// Port-level assertions for the stick dead zone block, bound to the top level.
`default_nettype none
module sard_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [15:0] out_x_i,
  input wire logic [15:0] out_y_i,
  input wire logic        dead_i
);

  a_dead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && dead_i |-> out_x_i == 16'd0 && out_y_i == 16'd0)
    else $error("dead zone result with nonzero output");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_x_i) && $stable(out_y_i)
      && $stable(dead_i))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result right after reset");

endmodule

bind stick_axial_radial_dead_zone sard_chk u_sard_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_x_i     (result_o.out_x),
  .out_y_i     (result_o.out_y),
  .dead_i      (result_o.in_dead_zone)
);
`default_nettype wire

/* tb/tb_stick_axial_radial_dead_zone.sv */
// Testbench for the stick axial/radial dead zone: random and directed readings checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_stick_axial_radial_dead_zone;
  import sard_pkg::*;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic               in_dead_zone;
  } cond_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_wdata_i = '0;

  sard_in_if stick_if ();
  sard_out_if result_if ();

  stick_axial_radial_dead_zone i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .stick_i    (stick_if.sink),
    .result_o   (result_if.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor settings
  logic [14:0] p_axis_thr;
  logic [16:0] p_gain_pos;
  logic [16:0] p_gain_neg;
  logic [14:0] p_rad_thr;
  logic [16:0] p_rad_gain;
  logic [14:0] p_mag_limit;

  cond_t expected_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_dead = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  function automatic logic [16:0] clamp_axis(logic neg, logic [63:0] m);
    if (neg) return (m >= 64'd32768) ? 17'd32768 : m[16:0];
    return (m >= 64'd32767) ? 17'd32767 : m[16:0];
  endfunction

  function automatic logic signed [16:0] condition_axis(logic signed [15:0] v);
    longint t;
    longint d;
    t = p_axis_thr;
    if (v > t) begin
      d = v - t;
      return $signed(clamp_axis(1'b0, (64'(d) * p_gain_pos) >> GainFracBits));
    end
    if (v < -t) begin
      d = -(v + t);
      return -$signed(clamp_axis(1'b1, (64'(d) * p_gain_neg) >> GainFracBits));
    end
    return '0;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic cond_t condition_stick(logic signed [15:0] sx, logic signed [15:0] sy);
    cond_t c;
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic [63:0] ax;
    logic [63:0] ay;
    logic [63:0] mag;
    logic [63:0] thr;
    logic [63:0] lim;
    logic [63:0] clamped;
    logic [63:0] radius;
    logic [16:0] mx;
    logic [16:0] my;
    x = condition_axis(sx);
    y = condition_axis(sy);
    ax = (x < 0) ? 64'(-x) : 64'(x);
    ay = (y < 0) ? 64'(-y) : 64'(y);
    mag = int_sqrt((ax * ax + ay * ay) << (2 * MagFracBits));
    thr = 64'(p_rad_thr) << MagFracBits;
    lim = 64'(p_mag_limit) << MagFracBits;
    clamped = (mag > lim) ? lim : mag;
    c = '0;
    if (mag <= thr || clamped < thr) begin
      c.in_dead_zone = 1'b1;
      return c;
    end
    radius = ((clamped - thr) * p_rad_gain) >> GainFracBits;
    mx = clamp_axis(x < 0, (ax * radius) / mag);
    my = clamp_axis(y < 0, (ay * radius) / mag);
    c.out_x = (x < 0) ? 16'(-mx) : mx[15:0];
    c.out_y = (y < 0) ? 16'(-my) : my[15:0];
    return c;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_AXIS_THR:  p_axis_thr = val[14:0];
      CFG_AXIS_GPOS: p_gain_pos = val;
      CFG_AXIS_GNEG: p_gain_neg = val;
      CFG_RAD_THR:   p_rad_thr = val[14:0];
      CFG_RAD_GAIN:  p_rad_gain = val;
      CFG_MAG_LIMIT: p_mag_limit = val[14:0];
      default: ;
    endcase
  endtask

  task automatic set_all(int at, int gp, int gn, int rt, int rg, int ml);
    write_reg(CFG_AXIS_THR, CfgW'(at));
    write_reg(CFG_AXIS_GPOS, CfgW'(gp));
    write_reg(CFG_AXIS_GNEG, CfgW'(gn));
    write_reg(CFG_RAD_THR, CfgW'(rt));
    write_reg(CFG_RAD_GAIN, CfgW'(rg));
    write_reg(CFG_MAG_LIMIT, CfgW'(ml));
  endtask

  // sends one reading; valid stays high across back-to-back transactions
  task automatic send_stick(logic signed [15:0] sx, logic signed [15:0] sy);
    while ($urandom_range(99) < send_idle_pct) begin
      stick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    stick_if.valid <= 1'b1;
    stick_if.stick_x <= sx;
    stick_if.stick_y <= sy;
    @(posedge clk_i);
    while (!stick_if.ready) @(posedge clk_i);
    expected_q.push_back(condition_stick(sx, sy));
    n_sent++;
  endtask

  task automatic drain();
    stick_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) result_if.ready <= 1'b0;
    else result_if.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cond_t exp_r;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        n_checked++;
        if (exp_r.in_dead_zone) n_dead++;
        if (result_if.out_x !== exp_r.out_x) begin
          $error("out_x expected %0d actual %0d", exp_r.out_x, result_if.out_x);
          errors++;
        end
        if (result_if.out_y !== exp_r.out_y) begin
          $error("out_y expected %0d actual %0d", exp_r.out_y, result_if.out_y);
          errors++;
        end
        if (result_if.in_dead_zone !== exp_r.in_dead_zone) begin
          $error("in_dead_zone expected %0b actual %0b", exp_r.in_dead_zone,
                 result_if.in_dead_zone);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((stick_if.valid && stick_if.ready) || (result_if.valid && result_if.ready)
        || cfg_we_i)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000 && !timed_out) begin
      timed_out = 1'b1;
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(5))
      0: return 16'($urandom_range(16'hffff));
      1: return 16'sh7fff - 16'($urandom_range(64));
      2: return -16'sh8000 + 16'($urandom_range(64));
      3: return 16'(int'(p_axis_thr) + $urandom_range(512) - 256);
      4: return 16'(-int'(p_axis_thr) + $urandom_range(512) - 256);
      default: return 16'($urandom_range(8000)) - 16'sd4000;
    endcase
  endfunction

  task automatic test_directed();
    logic signed [15:0] v[8];
    v = '{16'sh7fff, -16'sh8000, 16'sd0, 16'sd4095, 16'sd4096, -16'sd4095, -16'sd4096, -16'sd1};
    foreach (v[i]) send_stick(v[i], v[(i + 3) % 8]);
    send_stick(16'sh7fff, 16'sh7fff);
    send_stick(-16'sh8000, -16'sh8000);
    send_stick(16'sh5555, -16'sh5556);
    send_stick(-16'sh2aab, 16'sh2aaa);
    drain();
    // zero radius, negative radius and zero limit
    set_all(0, 65536, 65536, 100, 65536, 100);
    send_stick(16'sd1000, 16'sd0);
    send_stick(16'sd50, 16'sd0);
    drain();
    set_all(0, 65536, 65536, 200, 65536, 100);
    send_stick(16'sd1000, -16'sd1000);
    drain();
    set_all(0, 65536, 65536, 0, 65536, 0);
    send_stick(16'sd1000, 16'sd7);
    drain();
  endtask

  task automatic test_random(int n);
    repeat (n) send_stick(rand_axis(), rand_axis());
  endtask

  task automatic test_settings();
    set_all(32767, 131071, 131071, 32767, 131071, 32767);
    test_random(40);
    drain();
    set_all(0, 0, 0, 0, 0, 1);
    test_random(40);
    drain();
    set_all(0, 131071, 131071, 0, 131071, 32767);
    test_random(80);
    drain();
    set_all($urandom_range(8000), $urandom_range(131071), $urandom_range(131071),
            $urandom_range(8000), $urandom_range(131071), $urandom_range(32767, 1));
    test_random(80);
    drain();
    set_all(4095, 74896, 74896, 4095, 74896, 32767);
  endtask

  task automatic test_backpressure();
    recv_hold = 1'b1;
    fork
      test_random(60);
      begin
        repeat (150) @(posedge clk_i);
        recv_hold = 1'b0;
      end
    join
    drain();
  endtask

  initial begin
    stick_if.valid = 1'b0;
    stick_if.stick_x = '0;
    stick_if.stick_y = '0;
    p_axis_thr = RST_AXIS_THR;
    p_gain_pos = RST_AXIS_GAIN;
    p_gain_neg = RST_AXIS_GAIN;
    p_rad_thr = RST_RAD_THR;
    p_rad_gain = RST_RAD_GAIN;
    p_mag_limit = RST_MAG_LIMIT;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle_pct = 27;
    recv_idle_pct = 64;
    test_random(250);
    drain();
    send_idle_pct = 64;
    recv_idle_pct = 27;
    test_settings();
    test_random(200);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(250);
    drain();
    $display("Sent %0d stick readings, checked %0d results (%0d in radial dead zone)",
             n_sent, n_checked, n_dead);
    $display("over reset, extreme and random register settings with stalls on both sides.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
